/* src/scpf_pkg.sv */
// Shared types and constants for the sensor command packet framer.
package scpf_pkg;

	localparam int BYTE_W = 8;
	localparam int CMD_W  = 16;
	localparam int LEN_W  = 12;
	localparam int ID_W   = 16;
	localparam int SUM_W  = 16;
	localparam int IDX_W  = 3;

	localparam int MAX_PAYLOAD_DEF = 4095;
	localparam int PAD_BYTES_DEF   = 16;

	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [BYTE_W-1:0] SYNC_CMD_0  = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_CMD_1  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_DATA_0 = 8'h5A;
	localparam logic [BYTE_W-1:0] SYNC_DATA_1 = 8'hA5;

	localparam logic [IDX_W-1:0] HDR_SYNC_0  = 3'd0;
	localparam logic [IDX_W-1:0] HDR_SYNC_1  = 3'd1;
	localparam logic [IDX_W-1:0] HDR_CMD_LO  = 3'd2;
	localparam logic [IDX_W-1:0] HDR_CMD_HI  = 3'd3;
	localparam logic [IDX_W-1:0] HDR_LEN_LO  = 3'd4;
	localparam logic [IDX_W-1:0] HDR_LEN_HI  = 3'd5;
	localparam logic [IDX_W-1:0] HDR_ID_LO   = 3'd6;
	localparam logic [IDX_W-1:0] HDR_ID_HI   = 3'd7;

	localparam logic [IDX_W-1:0] HDR_LAST_CMD  = HDR_LEN_HI;
	localparam logic [IDX_W-1:0] HDR_LAST_DATA = HDR_ID_HI;

	typedef struct packed {
		logic load_hdr;
		logic hdr_emit;
		logic pay_emit;
		logic pad_emit;
		logic ck_lo_emit;
		logic ck_hi_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic emit_ok;
		logic hdr_last;
		logic len_zero;
		logic kind;
		logic open;
		logic pay_last;
		logic pad_more;
	} dp_status_t;

endpackage

/* src/scpf_in_if.sv */
// Request channel: header or payload byte toward the framer.
interface scpf_in_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic                          packet_kind;
	logic [scpf_pkg::CMD_W-1:0]    command;
	logic [scpf_pkg::LEN_W-1:0]    length;
	logic [scpf_pkg::ID_W-1:0]     template_id;
	logic [scpf_pkg::BYTE_W-1:0]   data_byte;

	modport source(output valid, req_type, packet_kind, command, length, template_id,
		data_byte, input ready);
	modport sink(input valid, req_type, packet_kind, command, length, template_id,
		data_byte, output ready);
endinterface

/* src/scpf_out_if.sv */
// Frame byte channel from the framer to the serial transmitter.
interface scpf_out_if;
	logic                          valid;
	logic                          ready;
	logic [scpf_pkg::BYTE_W-1:0]   out_byte;
	logic                          last;

	modport source(output valid, out_byte, last, input ready);
	modport sink(input valid, out_byte, last, output ready);
endinterface

/* src/scpf_ctrl.sv */
// Frame sequencing state machine of the packet framer.
module scpf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_req_type,
	input  scpf_pkg::dp_status_t   status,
	output scpf_pkg::ctrl_cmd_t    cmd,
	output logic                   in_ready
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HDR  = 5'b00010,
		S_PAD  = 5'b00100,
		S_CKLO = 5'b01000,
		S_CKHI = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == S_IDLE) && status.emit_ok;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.load_hdr   = acc && (in_req_type == scpf_pkg::REQ_HEADER);
		cmd.pay_emit   = acc && (in_req_type == scpf_pkg::REQ_PAYLOAD) && status.open;
		cmd.hdr_emit   = (state_q == S_HDR) && status.emit_ok;
		cmd.pad_emit   = (state_q == S_PAD) && status.emit_ok;
		cmd.ck_lo_emit = (state_q == S_CKLO) && status.emit_ok;
		cmd.ck_hi_emit = (state_q == S_CKHI) && status.emit_ok;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load_hdr) begin
					state_d = S_HDR;
				end else if (cmd.pay_emit && status.pay_last) begin
					state_d = (status.kind == scpf_pkg::KIND_CMD && status.pad_more)
						? S_PAD : S_CKLO;
				end
			end
			S_HDR: begin
				if (cmd.hdr_emit && status.hdr_last) begin
					// a non-empty packet waits in idle for payload; an empty command goes to padding
					if (!status.len_zero) begin
						state_d = S_IDLE;
					end else if (status.kind == scpf_pkg::KIND_CMD) begin
						state_d = S_PAD;
					end else begin
						state_d = S_CKLO;
					end
				end
			end
			S_PAD: begin
				if (cmd.pad_emit && !status.pad_more) begin
					state_d = S_CKLO;
				end
			end
			S_CKLO: begin
				if (cmd.ck_lo_emit) begin
					state_d = S_CKHI;
				end
			end
			S_CKHI: begin
				if (cmd.ck_hi_emit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/scpf_datapath.sv */
// Header registers, counters, running sum and output register of the framer.
module scpf_datapath #(
	parameter int MAX_PAYLOAD = scpf_pkg::MAX_PAYLOAD_DEF,
	parameter int PAD_BYTES   = scpf_pkg::PAD_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scpf_pkg::ctrl_cmd_t           cmd,
	output scpf_pkg::dp_status_t          status,
	input  logic                          packet_kind,
	input  logic [scpf_pkg::CMD_W-1:0]    command,
	input  logic [scpf_pkg::LEN_W-1:0]    length,
	input  logic [scpf_pkg::ID_W-1:0]     template_id,
	input  logic [scpf_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [scpf_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last
);

	logic                          kind_q;
	logic [scpf_pkg::CMD_W-1:0]    cmd_q;
	logic [scpf_pkg::ID_W-1:0]     id_q;
	logic [scpf_pkg::LEN_W-1:0]    expected_q;
	logic [scpf_pkg::LEN_W-1:0]    seen_q;
	logic [scpf_pkg::IDX_W-1:0]    idx_q;
	logic [scpf_pkg::SUM_W-1:0]    sum_q;
	logic                          open_q;
	logic                          out_valid_q;
	logic [scpf_pkg::BYTE_W-1:0]   out_byte_q;
	logic                          last_q;

	logic [scpf_pkg::LEN_W-1:0]    len_clamped;
	logic [scpf_pkg::SUM_W-1:0]    len_field;
	logic [scpf_pkg::BYTE_W-1:0]   hdr_byte;
	logic [scpf_pkg::BYTE_W-1:0]   emit_byte;
	logic                          emit_any;
	logic                          summed;

	always_comb begin
		len_clamped = length;
		if (packet_kind == scpf_pkg::KIND_CMD) begin
			if (32'(length) > 32'(PAD_BYTES)) len_clamped = scpf_pkg::LEN_W'(PAD_BYTES);
		end else begin
			if (32'(length) > 32'(MAX_PAYLOAD)) len_clamped = scpf_pkg::LEN_W'(MAX_PAYLOAD);
		end
	end

	// data packets announce the payload length plus the two template ID bytes
	assign len_field = (kind_q == scpf_pkg::KIND_DATA)
		? scpf_pkg::SUM_W'(expected_q) + scpf_pkg::SUM_W'(2)
		: scpf_pkg::SUM_W'(expected_q);

	always_comb begin
		unique case (idx_q)
			scpf_pkg::HDR_SYNC_0: hdr_byte = (kind_q == scpf_pkg::KIND_DATA)
				? scpf_pkg::SYNC_DATA_0 : scpf_pkg::SYNC_CMD_0;
			scpf_pkg::HDR_SYNC_1: hdr_byte = (kind_q == scpf_pkg::KIND_DATA)
				? scpf_pkg::SYNC_DATA_1 : scpf_pkg::SYNC_CMD_1;
			scpf_pkg::HDR_CMD_LO: hdr_byte = cmd_q[7:0];
			scpf_pkg::HDR_CMD_HI: hdr_byte = cmd_q[15:8];
			scpf_pkg::HDR_LEN_LO: hdr_byte = len_field[7:0];
			scpf_pkg::HDR_LEN_HI: hdr_byte = len_field[15:8];
			scpf_pkg::HDR_ID_LO:  hdr_byte = id_q[7:0];
			scpf_pkg::HDR_ID_HI:  hdr_byte = id_q[15:8];
			default:              hdr_byte = '0;
		endcase
	end

	assign summed   = cmd.hdr_emit || cmd.pay_emit || cmd.pad_emit;
	assign emit_any = summed || cmd.ck_lo_emit || cmd.ck_hi_emit;

	always_comb begin
		priority if (cmd.hdr_emit) begin
			emit_byte = hdr_byte;
		end else if (cmd.pay_emit) begin
			emit_byte = data_byte;
		end else if (cmd.pad_emit) begin
			emit_byte = '0;
		end else if (cmd.ck_lo_emit) begin
			emit_byte = sum_q[7:0];
		end else begin
			emit_byte = sum_q[15:8];
		end
	end

	always_comb begin
		status          = '0;
		status.emit_ok  = !out_valid_q || out_ready;
		status.hdr_last = (idx_q == ((kind_q == scpf_pkg::KIND_DATA)
			? scpf_pkg::HDR_LAST_DATA : scpf_pkg::HDR_LAST_CMD));
		status.len_zero = (expected_q == '0);
		status.kind     = kind_q;
		status.open     = open_q;
		status.pay_last = ({1'b0, seen_q} + (scpf_pkg::LEN_W+1)'(1)) >= {1'b0, expected_q};
		status.pad_more = (32'(seen_q) + 32'd1) < 32'(PAD_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
			seen_q      <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
		end else begin
			if (cmd.load_hdr) begin
				open_q <= 1'b1;
				seen_q <= '0;
				idx_q  <= '0;
				sum_q  <= '0;
			end else begin
				if (summed) sum_q <= sum_q + scpf_pkg::SUM_W'(emit_byte);
				if (cmd.hdr_emit) idx_q <= idx_q + scpf_pkg::IDX_W'(1);
				if (cmd.pay_emit || cmd.pad_emit) seen_q <= seen_q + scpf_pkg::LEN_W'(1);
				if (cmd.ck_hi_emit) open_q <= 1'b0;
			end
			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hdr) begin
			kind_q     <= packet_kind;
			cmd_q      <= command;
			id_q       <= template_id;
			expected_q <= len_clamped;
		end
		if (emit_any) begin
			out_byte_q <= emit_byte;
			last_q     <= cmd.ck_hi_emit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

/* src/sensor_command_packet_framer.sv */
// Packet framer top level: request channel in, frame byte channel out.
// A payload byte is written into the output register as its request is accepted.
// A header request yields 6 (command) or 8 (data) bytes, one per cycle unless the
// sink stalls, after acceptance; any padding and both checksum bytes follow likewise.
// Throughput: one payload request per cycle; requests stall while the header,
// padding and checksum bytes go out or the output register is held by the sink.
// Reset: asynchronous, clears the state machine, output valid and the open packet.
module sensor_command_packet_framer #(
	parameter int MAX_PAYLOAD = scpf_pkg::MAX_PAYLOAD_DEF,
	parameter int PAD_BYTES   = scpf_pkg::PAD_BYTES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	scpf_in_if.sink    request,
	scpf_out_if.source frame
);

	scpf_pkg::ctrl_cmd_t  cmd;
	scpf_pkg::dp_status_t status;

	scpf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (request.valid),
		.in_req_type (request.req_type),
		.status      (status),
		.cmd         (cmd),
		.in_ready    (request.ready)
	);

	scpf_datapath #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.PAD_BYTES   (PAD_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.packet_kind (request.packet_kind),
		.command     (request.command),
		.length      (request.length),
		.template_id (request.template_id),
		.data_byte   (request.data_byte),
		.out_ready   (frame.ready),
		.out_valid   (frame.valid),
		.out_byte    (frame.out_byte),
		.last        (frame.last)
	);

endmodule

/* src/scpf_checker.sv */
// Port-level checks of the packet framer, bound to the top level.
module scpf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_req_type,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [scpf_pkg::BYTE_W-1:0]   out_byte,
	input logic                          last
);

	// hold a stalled frame byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("frame byte changed while stalled");

	// a request is taken only when the output register can take its byte
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("request ready while output register is blocked");

	// header bytes go out before the next request
	a_hdr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_req_type == scpf_pkg::REQ_HEADER) |=> !in_ready)
		else $error("request ready right after a header");

endmodule

bind sensor_command_packet_framer scpf_checker u_scpf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (request.valid),
	.in_ready    (request.ready),
	.in_req_type (request.req_type),
	.out_valid   (frame.valid),
	.out_ready   (frame.ready),
	.out_byte    (frame.out_byte),
	.last        (frame.last)
);
